// ----- design/qeld_pkg.sv -----
package qeld_pkg;

  // Command codes of an input word.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Configuration register indexes.
  localparam logic REG_TABLE_LOW  = 1'b0;
  localparam logic REG_TABLE_HIGH = 1'b1;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OUT_TOTAL_W = 8;

  // Reset contents of the transition table (normal direction).
  localparam logic [CFG_DATA_W-1:0] TABLE_LOW_RESET  = 64'h0400_0002_0011_F400;
  localparam logic [CFG_DATA_W-1:0] TABLE_HIGH_RESET = 64'h00F8_1200_0100_0008;

  typedef struct packed {
    logic       cmd;
    logic [1:0] pin_state;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_TOTAL_W-1:0] total;
    logic                          stepped;
  } out_word_t;

  // Table contents and the pulse that forgets the previous entry.
  typedef struct packed {
    logic [2*CFG_DATA_W-1:0] entries;
    logic                    clr_prev;
  } table_cfg_t;

endpackage

// ----- design/qeld_regs.sv -----
module qeld_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [qeld_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output qeld_pkg::table_cfg_t                table_o
);
  import qeld_pkg::*;

  logic [CFG_DATA_W-1:0] low_q, low_d;
  logic [CFG_DATA_W-1:0] high_q, high_d;

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TABLE_LOW:  low_d  = cfg_data_i;
        REG_TABLE_HIGH: high_d = cfg_data_i;
        default:        low_d  = low_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= TABLE_LOW_RESET;
      high_q <= TABLE_HIGH_RESET;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // Any table write invalidates the remembered transition entry.
  assign table_o.entries  = {high_q, low_q};
  assign table_o.clr_prev = cfg_we_i;

endmodule

// ----- design/qeld_core.sv -----
module qeld_core #(
  parameter int unsigned TOTAL_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qeld_pkg::table_cfg_t  table_i,
  input  logic                  fire_i,
  input  qeld_pkg::in_word_t    word_i,
  output qeld_pkg::out_word_t   result_o
);
  import qeld_pkg::*;

  logic [1:0]                   prev_pins_q, prev_pins_d;
  logic [7:0]                   prev_entry_q, prev_entry_d;
  logic signed [TOTAL_WIDTH-1:0] acc_q, acc_d;

  logic [3:0]                   idx;
  logic [7:0]                   entry;
  logic signed [3:0]            delta;
  logic signed [TOTAL_WIDTH:0]  sum;
  logic signed [TOTAL_WIDTH-1:0] sat_sum;
  logic                         changed;
  logic                         do_step;

  // Transition index is previous | new << 2.
  assign idx     = {word_i.pin_state, prev_pins_q};
  assign entry   = table_i.entries[{idx, 3'b000} +: 8];
  assign delta   = signed'(entry[7:4]);
  assign changed = (word_i.pin_state != prev_pins_q);
  assign do_step = changed && ((entry[3:0] & prev_entry_q[3:0]) != 4'd0);

  assign sum = {acc_q[TOTAL_WIDTH-1], acc_q}
             + {{(TOTAL_WIDTH-3){delta[3]}}, delta};

  always_comb begin
    if (sum[TOTAL_WIDTH] != sum[TOTAL_WIDTH-1]) begin
      sat_sum = sum[TOTAL_WIDTH] ? {1'b1, {(TOTAL_WIDTH-1){1'b0}}}
                                 : {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
    end else begin
      sat_sum = sum[TOTAL_WIDTH-1:0];
    end
  end

  always_comb begin
    prev_pins_d  = prev_pins_q;
    prev_entry_d = prev_entry_q;
    acc_d        = acc_q;
    result_o.stepped = 1'b0;
    result_o.total   = OUT_TOTAL_W'(acc_q);
    case (word_i.cmd)
      CMD_READ: begin
        acc_d = '0;
      end
      default: begin
        if (changed) begin
          prev_pins_d  = word_i.pin_state;
          prev_entry_d = entry;
          if (do_step) begin
            acc_d            = sat_sum;
            result_o.stepped = 1'b1;
            result_o.total   = OUT_TOTAL_W'(sat_sum);
          end
        end
      end
    endcase
    if (!fire_i) begin
      prev_pins_d  = prev_pins_q;
      prev_entry_d = prev_entry_q;
      acc_d        = acc_q;
    end
    if (table_i.clr_prev) begin
      prev_entry_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pins_q  <= '0;
      prev_entry_q <= '0;
      acc_q        <= '0;
    end else begin
      prev_pins_q  <= prev_pins_d;
      prev_entry_q <= prev_entry_d;
      acc_q        <= acc_d;
    end
  end

endmodule

// ----- design/quadrature_encoder_lut_decoder.sv -----
// Table-driven quadrature decoder for one rotary encoder.
// Input channel (in_valid_i / in_ready_o / in_data_i): each word is either a
// debounced A/B pin sample or a read command. A sample that differs from the
// last one looks up a 16-entry byte table; the signed upper nibble is added to
// a saturating accumulator when the entry's low nibble shares a bit with the
// previous transition's entry. A read returns the accumulator and clears it.
// Output channel (out_valid_o / out_ready_i / out_data_o): one result word per
// input word, in order.
// The result is registered: the input register holds the accepted word, then
// lookup and add feed the result register.
// Throughput: one word per cycle, limited only by the output handshake.
// When the receiver stalls, the held result and one word in the input register
// wait; the input side stops taking words once both are occupied.
// Reset loads the normal-direction table and clears pins, entry and total.
// Table writes go through the configuration port and forget the previous
// transition entry; the user must write only while the block is idle (not enforced).
module quadrature_encoder_lut_decoder #(
  parameter int unsigned TOTAL_WIDTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [qeld_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  qeld_pkg::in_word_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output qeld_pkg::out_word_t             out_data_o
);
  import qeld_pkg::*;

  table_cfg_t table_cfg;
  in_word_t   in_word_q;
  logic       in_valid_q;
  out_word_t  result;
  out_word_t  out_word_q;
  logic       out_valid_q;
  logic       advance;

  // The input register moves on whenever the result register is free or
  // being emptied in this cycle.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  qeld_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .table_o    (table_cfg)
  );

  qeld_core #(
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .table_i  (table_cfg),
    .fire_i   (in_valid_q && advance),
    .word_i   (in_word_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_data_i;
    end
    if (advance && in_valid_q) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

// ----- design/qeld_checker.sv -----
module qeld_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input qeld_pkg::out_word_t out_data_o
);
  import qeld_pkg::*;

  logic                          has_last_q;
  logic signed [OUT_TOTAL_W-1:0] last_total_q;
  logic signed [OUT_TOTAL_W:0]   diff;
  logic                          small_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_last_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      has_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      last_total_q <= out_data_o.total;
    end
  end

  assign diff = {out_data_o.total[OUT_TOTAL_W-1], out_data_o.total}
              - {last_total_q[OUT_TOTAL_W-1], last_total_q};
  assign small_total = (out_data_o.total >= -8) && (out_data_o.total <= 7);

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // The input side only backs up when a result is waiting on the receiver.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // Without a step the total either repeats or has just been cleared.
  a_no_step_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_last_q && !out_data_o.stepped |->
      (out_data_o.total == last_total_q) || (out_data_o.total == 0))
    else $error("total moved without a step");

  // A step moves the total by at most one table delta.
  a_step_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_last_q && out_data_o.stepped |->
      ((diff >= -8) && (diff <= 7)) || small_total)
    else $error("step larger than a table delta");

endmodule

bind quadrature_encoder_lut_decoder qeld_checker u_qeld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- tb/quadrature_encoder_lut_decoder_tb.sv -----
module quadrature_encoder_lut_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qeld_pkg::*;

  // Accumulator width of the instance, and the saturation bounds that follow.
  localparam int TOTAL_W = 8;
  localparam int ACC_MAX = (1 << (TOTAL_W - 1)) - 1;
  localparam int ACC_MIN = -(1 << (TOTAL_W - 1));

  // Table contents after reset, copied from the block description.
  localparam logic [63:0] TBL_LO_AT_RESET = 64'h0400_0002_0011_F400;
  localparam logic [63:0] TBL_HI_AT_RESET = 64'h00F8_1200_0100_0008;

  // Every entry +7 with all low bits set, so every change but the first after a write steps; likewise -8.
  localparam logic [63:0] TBL_ALL_UP   = {8{8'h7F}};
  localparam logic [63:0] TBL_ALL_DOWN = {8{8'h8F}};

  // Cycles to let pass before a table write once the pipe looks empty.
  localparam int SETTLE_CYCLES = 3;
  localparam int WORDS_PER_PHASE = 210;
  localparam int N_PHASES = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_word_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_word_t             out_data_o;

  quadrature_encoder_lut_decoder #(
    .TOTAL_WIDTH(TOTAL_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Decoder state as the testbench sees it: the transition table, the last
  // pin sample, the entry of the last transition and the step accumulator.
  logic [63:0]              tbl_lo;
  logic [63:0]              tbl_hi;
  logic [1:0]               last_pins;
  logic [7:0]               last_entry;
  logic signed [TOTAL_W-1:0] acc;

  // Decoded result words, oldest first, waiting for the output channel.
  out_word_t decoded_q[$];
  int        mismatches;

  // Idling of the two sides, in percent of cycles.
  int send_idle_pct;
  int recv_stall_pct;

  // Stimulus bookkeeping: the pins last sent and the direction of rotation.
  logic [1:0] sent_pins;
  bit         walk_back;

  typedef enum int {ROW_WORD, ROW_TABLE} row_kind_e;

  // One row of the directed script. A word row is sent reps times, with the
  // pins advancing by one each time, so every repetition is a real change.
  // Where typed is set, want is the expected result instead of the predictor.
  typedef struct {
    row_kind_e   kind;
    in_word_t    word;
    int          reps;
    bit          typed;
    out_word_t   want;
    logic        cfg_idx;
    logic [63:0] cfg_data;
  } dir_row_t;

  localparam int N_ROWS = 17;

  dir_row_t script [N_ROWS] = '{
    // A read right after reset returns an empty accumulator.
    '{ROW_WORD, '{CMD_READ, 2'd3}, 1, 1'b1, '{8'sd0, 1'b0}, REG_TABLE_LOW, 64'd0},
    // The reset pins are 0, so sample 0 is unchanged.
    '{ROW_WORD, '{CMD_SAMPLE, 2'd0}, 1, 1'b1, '{8'sd0, 1'b0}, REG_TABLE_LOW, 64'd0},
    // A short forward walk with the normal-direction table.
    '{ROW_WORD, '{CMD_SAMPLE, 2'd1}, 1, 1'b0, '{8'sd0, 1'b0}, REG_TABLE_LOW, 64'd0},
    '{ROW_WORD, '{CMD_SAMPLE, 2'd3}, 1, 1'b0, '{8'sd0, 1'b0}, REG_TABLE_LOW, 64'd0},
    '{ROW_WORD, '{CMD_SAMPLE, 2'd2}, 1, 1'b0, '{8'sd0, 1'b0}, REG_TABLE_LOW, 64'd0},
    '{ROW_WORD, '{CMD_READ, 2'd0}, 1, 1'b0, '{8'sd0, 1'b0}, REG_TABLE_LOW, 64'd0},
    // Load a table where every change is worth +7.
    '{ROW_TABLE, '{CMD_SAMPLE, 2'd0}, 0, 1'b0, '{8'sd0, 1'b0}, REG_TABLE_LOW, TBL_ALL_UP},
    '{ROW_TABLE, '{CMD_SAMPLE, 2'd0}, 0, 1'b0, '{8'sd0, 1'b0}, REG_TABLE_HIGH, TBL_ALL_UP},
    // The write forgot the previous entry, so the first change cannot step.
    '{ROW_WORD, '{CMD_SAMPLE, 2'd0}, 1, 1'b1, '{8'sd0, 1'b0}, REG_TABLE_LOW, 64'd0},
    // Twenty steps of +7 drive the accumulator into its upper bound.
    '{ROW_WORD, '{CMD_SAMPLE, 2'd1}, 20, 1'b0, '{8'sd0, 1'b0}, REG_TABLE_LOW, 64'd0},
    '{ROW_WORD, '{CMD_READ, 2'd2}, 1, 1'b1, '{8'sd127, 1'b0}, REG_TABLE_LOW, 64'd0},
    // The read kept the previous entry, so the next change steps at once.
    '{ROW_WORD, '{CMD_SAMPLE, 2'd1}, 1, 1'b1, '{8'sd7, 1'b1}, REG_TABLE_LOW, 64'd0},
    // Back to the reset table.
    '{ROW_TABLE, '{CMD_SAMPLE, 2'd0}, 0, 1'b0, '{8'sd0, 1'b0}, REG_TABLE_LOW, TBL_LO_AT_RESET},
    '{ROW_TABLE, '{CMD_SAMPLE, 2'd0}, 0, 1'b0, '{8'sd0, 1'b0}, REG_TABLE_HIGH, TBL_HI_AT_RESET},
    '{ROW_WORD, '{CMD_SAMPLE, 2'd1}, 1, 1'b1, '{8'sd7, 1'b0}, REG_TABLE_LOW, 64'd0},
    '{ROW_WORD, '{CMD_READ, 2'd1}, 1, 1'b1, '{8'sd7, 1'b0}, REG_TABLE_LOW, 64'd0},
    '{ROW_WORD, '{CMD_READ, 2'd0}, 1, 1'b1, '{8'sd0, 1'b0}, REG_TABLE_LOW, 64'd0}
  };

  // Decode one accepted input word against the testbench's own copy of the
  // state, and return the result word the block must produce for it.
  function automatic out_word_t decode_word(in_word_t w);
    out_word_t   res;
    logic [3:0]  idx;
    logic [63:0] half;
    logic [7:0]  entry;
    int          delta;
    int          sum;
    res.stepped = 1'b0;
    if (w.cmd == CMD_READ) begin
      // A read hands out the accumulator and clears it; pins and entry stay.
      res.total = acc;
      acc = '0;
      return res;
    end
    if (w.pin_state != last_pins) begin
      idx = {w.pin_state, last_pins};
      half = idx[3] ? tbl_hi : tbl_lo;
      entry = half[idx[2:0] * 8 +: 8];
      delta = $signed(entry[7:4]);
      // Only a transition that agrees with the previous one moves the count.
      if ((entry[3:0] & last_entry[3:0]) != 4'd0) begin
        sum = acc + delta;
        if (sum > ACC_MAX) begin
          sum = ACC_MAX;
        end
        if (sum < ACC_MIN) begin
          sum = ACC_MIN;
        end
        acc = sum[TOTAL_W-1:0];
        res.stepped = 1'b1;
      end
      last_entry = entry;
      last_pins = w.pin_state;
    end
    res.total = acc;
    return res;
  endfunction

  // Next random word. Most words walk the Gray sequence in the current
  // direction, which is what gets transitions past the agreement test; the
  // rest are reads, repeats, two-bit jumps and arbitrary pins.
  function automatic in_word_t next_encoder_word(int read_pct);
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    w.cmd = CMD_SAMPLE;
    w.pin_state = sent_pins;
    if (pick < read_pct) begin
      w.cmd = CMD_READ;
      w.pin_state = 2'($urandom_range(0, 3));
    end else if (pick < read_pct + 5) begin
      w.pin_state = sent_pins;
    end else if (pick < read_pct + 10) begin
      w.pin_state = sent_pins ^ 2'b11;
    end else if (pick < read_pct + 13) begin
      w.pin_state = 2'($urandom_range(0, 3));
    end else begin
      if ($urandom_range(0, 99) < 8) begin
        walk_back = ~walk_back;
      end
      w.pin_state = walk_back ? {~sent_pins[0], sent_pins[1]}
                              : {sent_pins[0], ~sent_pins[1]};
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one word on the input channel and hold it until it is taken. The
  // sender may first idle at random. Called at a rising edge; returns
  // at the edge that accepted the word, so the next word can follow at once.
  task automatic push_word(in_word_t w, bit typed, out_word_t want);
    out_word_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    got = decode_word(w);
    decoded_q.push_back(typed ? want : got);
    if (w.cmd == CMD_SAMPLE) begin
      sent_pins = w.pin_state;
    end
  endtask

  // Stop sending and wait until every decoded word has come out.
  task automatic drain_pending();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write one half of the table while the block is idle. The write also
  // makes the block forget the previous transition entry.
  task automatic write_table(logic idx, logic [63:0] data);
    drain_pending();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TABLE_LOW) begin
      tbl_lo = data;
    end else begin
      tbl_hi = data;
    end
    last_entry = '0;
  endtask

  // Table with random deltas where each entry sets exactly one low bit.
  function automatic logic [63:0] one_bit_table();
    logic [63:0] t;
    logic [3:0]  hi;
    logic [3:0]  lo;
    for (int b = 0; b < 8; b++) begin
      hi = 4'($urandom_range(0, 15));
      lo = 4'b0001 << $urandom_range(0, 3);
      t[b * 8 +: 8] = {hi, lo};
    end
    return t;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Output side: check each result word as it is taken, then decide at
  // random whether to stall the next cycle.
  initial begin
    out_word_t got;
    out_word_t want;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word total %0d stepped %0b",
                                    got.total, got.stepped));
        end else begin
          want = decoded_q.pop_front();
          if (got.total !== want.total) begin
            report_mismatch($sformatf("total %0d, expected %0d", got.total, want.total));
          end
          if (got.stepped !== want.stepped) begin
            report_mismatch($sformatf("stepped %0b, expected %0b",
                                      got.stepped, want.stepped));
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Hard limit on the run; a healthy run ends far sooner.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_word_t    w;
    out_word_t   none;
    logic [63:0] lo;
    logic [63:0] hi;
    int          read_pct;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TABLE_LOW;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    none = '0;
    mismatches = 0;
    send_idle_pct = 30;
    recv_stall_pct = 30;
    sent_pins = 2'd0;
    walk_back = 1'b0;
    tbl_lo = TBL_LO_AT_RESET;
    tbl_hi = TBL_HI_AT_RESET;
    last_pins = 2'd0;
    last_entry = 8'd0;
    acc = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script: reset state, unchanged sample, table writes, the
    // upper saturation bound and a read that keeps the transition history.
    foreach (script[i]) begin
      if (script[i].kind == ROW_TABLE) begin
        write_table(script[i].cfg_idx, script[i].cfg_data);
      end else begin
        for (int r = 0; r < script[i].reps; r++) begin
          w = script[i].word;
          w.pin_state = w.pin_state + r[1:0];
          push_word(w, script[i].typed, script[i].want);
        end
      end
    end

    // Random phases. Each one loads a table setting, picks an idling mode
    // and sends a batch of words, pausing halfway until the pipe is empty.
    for (int p = 0; p < N_PHASES; p++) begin
      read_pct = 6;
      case (p)
        0: begin
          lo = TBL_LO_AT_RESET;
          hi = TBL_HI_AT_RESET;
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          lo = '0;
          hi = '1;
          send_idle_pct = 45;
          recv_stall_pct = 0;
        end
        2: begin
          lo = '1;
          hi = '0;
          send_idle_pct = 0;
          recv_stall_pct = 45;
        end
        3: begin
          // Large negative steps and rare reads reach the lower bound.
          lo = TBL_ALL_DOWN;
          hi = TBL_ALL_DOWN;
          read_pct = 1;
          send_idle_pct = 30;
          recv_stall_pct = 30;
        end
        4: begin
          lo = TBL_ALL_UP;
          hi = TBL_ALL_UP;
          read_pct = 1;
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        5: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
          send_idle_pct = 45;
          recv_stall_pct = 0;
        end
        6: begin
          lo = one_bit_table();
          hi = one_bit_table();
          send_idle_pct = 0;
          recv_stall_pct = 45;
        end
        default: begin
          lo = TBL_LO_AT_RESET;
          hi = TBL_HI_AT_RESET;
          send_idle_pct = 30;
          recv_stall_pct = 30;
        end
      endcase
      write_table(REG_TABLE_LOW, lo);
      write_table(REG_TABLE_HIGH, hi);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n == WORDS_PER_PHASE / 2) begin
          drain_pending();
        end
        w = next_encoder_word(read_pct);
        push_word(w, 1'b0, none);
      end
    end

    // Let the last words come out, then keep watching for strays.
    drain_pending();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
